### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// Clocked checks, disabled while reset is asserted. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the PID channel
// Widths, register indexes, sequencer codes and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int OUT_W     = 48;
  localparam int GAIN_W    = 32;
  localparam int TIME_W    = 17;
  localparam int RATE_W    = 31;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int WIDE_W    = 80;
  localparam int ACC_W     = 50;
  localparam int DLO_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [TIME_W-1:0] TIME_RESET = TIME_W'(65536);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

  localparam logic signed [WIDE_W-1:0] OUT_MAX_W = WIDE_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] OUT_MIN_W = ~OUT_MAX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_STEP_TIME = 3'd3,
    CFG_STEP_RATE = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IT,
    ST_P,
    ST_DR,
    ST_I,
    ST_DLO,
    ST_DHI,
    ST_DWB,
    ST_SUM
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_IT,
    MOP_P,
    MOP_DR,
    MOP_I,
    MOP_DLO,
    MOP_DHI
  } mul_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_IT,
    WB_P,
    WB_DR,
    WB_I,
    WB_DLO,
    WB_DHI
  } wb_op_t;

  typedef struct packed {
    logic    accept;
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    load_out;
  } cmd_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX_W) begin
      r = OUT_MAX_W[OUT_W-1:0];
    end else if (v < OUT_MIN_W) begin
      r = OUT_MIN_W[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/pid_step_with_integral_clamp_unit.sv
// ----------------------------------------------------------------------------
// pid_step_with_integral_clamp_unit: one PID channel in signed fixed point
// Six products share one multiplier, so a new transaction is accepted only once
// the previous result is loaded into the output register.
// Reset: integral and last error 0, gains 0, step_time and step_rate 65536.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pid_step_with_integral_clamp_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pidc_pkg::DATA_W-1:0]        s_tdata,    // error_in [31:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pidc_pkg::OUT_W-1:0]         m_tdata,    // drive_out [47:0]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidc_pkg::CFG_W-1:0]         cfg_data
);
  import pidc_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  pidc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .error_in  (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .drive_out (m_tdata)
  );

  `ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, cmd.mul_op == MOP_IT, "accepted transaction did not start the product sequence")
  `ASSERT_IMPLIES(a_accept_no_wb, clk, rst, s_tvalid && s_tready, cmd.wb_op == WB_NONE && cmd.mul_op == MOP_NONE, "transaction accepted while products in flight")
  `ASSERT_IMPLIES(a_load_free, clk, rst, cmd.load_out, !m_tvalid || m_tready, "result overwritten before transfer")
  `ASSERT_NEXT(a_load_valid, clk, rst, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

`default_nettype wire

### rtl/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul: shared signed multiplier
// One signed 33x33 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
  input  logic                                  clk,
  input  logic signed [pidc_pkg::MUL_W-1:0]     a,
  input  logic signed [pidc_pkg::MUL_W-1:0]     b,
  output logic signed [pidc_pkg::PROD_W-1:0]    prod
);
  import pidc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

### rtl/pidc_dp.sv
// ----------------------------------------------------------------------------
// pidc_dp: PID datapath
// Configuration registers, loop state, operand selection for the shared
// multiplier, write-back of scaled products and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pidc_pkg::cmd_t                      cmd,
  input  logic [pidc_pkg::DATA_W-1:0]         error_in,
  input  logic                                cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidc_pkg::CFG_W-1:0]          cfg_data,
  output logic [pidc_pkg::OUT_W-1:0]          drive_out
);
  import pidc_pkg::*;

  localparam int IW = FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] INT_ONE = PROD_W'(64'sd1) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] INT_NEG = -INT_ONE;

  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic [TIME_W-1:0]        step_time;
  logic [RATE_W-1:0]        step_rate;
  logic signed [IW-1:0]     integral_acc;
  logic signed [DATA_W-1:0] last_error;

  logic signed [DATA_W-1:0] err;
  logic signed [MUL_W-1:0]  diff;
  logic signed [OUT_W-1:0]  deriv;
  logic signed [PROD_W-1:0] dlo;
  logic signed [OUT_W-1:0]  dterm;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OUT_W-1:0]  drive;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [WIDE_W-1:0] prod_ext;
  logic signed [OUT_W-1:0]  prod_sat;
  logic signed [PROD_W-1:0] it_sum;
  logic signed [PROD_W-1:0] it_clamp;
  logic signed [WIDE_W-1:0] dh_full;
  logic signed [OUT_W-1:0]  dh_sat;
  logic signed [WIDE_W-1:0] sum_full;
  logic signed [OUT_W-1:0]  out_sat;

  pidc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MOP_IT: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'(step_time);
      end
      MOP_P: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'(gain_p);
      end
      MOP_DR: begin
        mul_a = diff;
        mul_b = MUL_W'(step_rate);
      end
      MOP_I: begin
        mul_a = MUL_W'(integral_acc);
        mul_b = MUL_W'(gain_i);
      end
      MOP_DLO: begin
        mul_a = MUL_W'(deriv[DLO_W-1:0]);
        mul_b = MUL_W'(gain_d);
      end
      MOP_DHI: begin
        mul_a = MUL_W'($signed(deriv[OUT_W-1:DLO_W]));
        mul_b = MUL_W'(gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_ext = WIDE_W'(prod);
    prod_sat = sat_out(prod_ext >>> FRAC_BITS);
    it_sum   = (prod >>> FRAC_BITS) + PROD_W'(integral_acc);
    if (it_sum > INT_ONE) begin
      it_clamp = INT_ONE;
    end else if (it_sum < INT_NEG) begin
      it_clamp = INT_NEG;
    end else begin
      it_clamp = it_sum;
    end
    dh_full  = (prod_ext <<< DLO_W) + WIDE_W'(dlo);
    dh_sat   = sat_out(dh_full >>> FRAC_BITS);
    sum_full = WIDE_W'(acc) + WIDE_W'(dterm);
    out_sat  = sat_out(sum_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      step_time    <= TIME_RESET;
      step_rate    <= RATE_RESET;
      integral_acc <= '0;
      last_error   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GAIN_P:    gain_p    <= $signed(cfg_data[GAIN_W-1:0]);
          CFG_GAIN_I:    gain_i    <= $signed(cfg_data[GAIN_W-1:0]);
          CFG_GAIN_D:    gain_d    <= $signed(cfg_data[GAIN_W-1:0]);
          CFG_STEP_TIME: step_time <= cfg_data[TIME_W-1:0];
          CFG_STEP_RATE: step_rate <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        last_error <= $signed(error_in);
      end
      if (cmd.wb_op == WB_IT) begin
        integral_acc <= it_clamp[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err  <= $signed(error_in);
      diff <= MUL_W'($signed(error_in)) - MUL_W'(last_error);
    end
    unique case (cmd.wb_op)
      WB_P:    acc   <= ACC_W'(prod_sat);
      WB_DR:   deriv <= prod_sat;
      WB_I:    acc   <= acc + ACC_W'(prod_sat);
      WB_DLO:  dlo   <= prod;
      WB_DHI:  dterm <= dh_sat;
      default: ;
    endcase
    if (cmd.load_out) begin
      drive <= out_sat;
    end
  end

  assign drive_out = drive;

endmodule

`default_nettype wire

### rtl/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl: PID sequencer
// Steps the six products through the shared multiplier, schedules their
// write-back and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output pidc_pkg::cmd_t cmd
);
  import pidc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_free   = !out_valid || m_tready;
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '{accept: 1'b0, mul_op: MOP_NONE, wb_op: WB_NONE, load_out: 1'b0};
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_IT;
        end
      end
      ST_IT: begin
        cmd.mul_op = MOP_IT;
        state_next = ST_P;
      end
      ST_P: begin
        cmd.mul_op = MOP_P;
        cmd.wb_op  = WB_IT;
        state_next = ST_DR;
      end
      ST_DR: begin
        cmd.mul_op = MOP_DR;
        cmd.wb_op  = WB_P;
        state_next = ST_I;
      end
      ST_I: begin
        cmd.mul_op = MOP_I;
        cmd.wb_op  = WB_DR;
        state_next = ST_DLO;
      end
      ST_DLO: begin
        cmd.mul_op = MOP_DLO;
        cmd.wb_op  = WB_I;
        state_next = ST_DHI;
      end
      ST_DHI: begin
        cmd.mul_op = MOP_DHI;
        cmd.wb_op  = WB_DLO;
        state_next = ST_DWB;
      end
      ST_DWB: begin
        cmd.wb_op  = WB_DHI;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          s_tready     = 1'b1;
          state_next   = s_tvalid ? ST_IT : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.accept = s_tvalid && s_tready;

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pid_step_with_integral_clamp_unit
// Streams signed Q16.16 error samples into one PID channel and predicts every
// drive_out from a fixed-point model kept beside the DUT (integral clamp,
// derivative through the rate register, 48-bit saturation). Gains and timing
// registers change between phases; both stream sides idle at random, the sink
// holds off once for a long stretch, and every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int FRAC          = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 250;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  localparam logic signed [95:0] SAT_HI    = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [95:0] SAT_LO    = ~SAT_HI;
  localparam logic signed [95:0] INTEG_ONE = 96'sd1 <<< FRAC;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pid_step_with_integral_clamp_unit #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // error_in [31:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // drive_out [47:0]
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channel settings and state as the DUT should hold them
  logic signed [31:0] gain_p_q    = '0;
  logic signed [31:0] gain_i_q    = '0;
  logic signed [31:0] gain_d_q    = '0;
  logic [16:0]        step_time_q = 17'd65536;
  logic [30:0]        step_rate_q = 31'd65536;
  logic signed [17:0] integ_q     = '0;
  logic signed [31:0] last_err_q  = '0;

  logic [DATA_W-1:0] pending_errors[$];
  logic [OUT_W-1:0]  drive_expected[$];

  int  tx_idle_pct  = 26;
  int  rx_idle_pct  = 69;
  int  items_queued = 0;
  int  items_taken  = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  failures     = 0;
  int  cycle_count  = 0;
  logic in_taken    = 1'b0;
  logic hold_req    = 1'b0;
  logic sink_stall  = 1'b0;

  function automatic logic signed [95:0] scaled(input logic signed [95:0] a,
                                                input logic signed [95:0] b);
    logic signed [95:0] p;
    p = (a * b) >>> FRAC;
    if (p > SAT_HI) p = SAT_HI;
    else if (p < SAT_LO) p = SAT_LO;
    return p;
  endfunction

  function automatic logic [OUT_W-1:0] pid_drive(input logic [DATA_W-1:0] err_bits);
    logic signed [95:0] err, integ, deriv, sum;
    err   = $signed(err_bits);
    integ = integ_q + scaled(err, step_time_q);
    if (integ > INTEG_ONE) integ = INTEG_ONE;
    if (integ < -INTEG_ONE) integ = -INTEG_ONE;
    integ_q = integ[17:0];
    deriv = scaled(err - last_err_q, step_rate_q);
    sum = scaled(err, gain_p_q) + scaled(integ, gain_i_q) + scaled(deriv, gain_d_q);
    if (sum > SAT_HI) sum = SAT_HI;
    else if (sum < SAT_LO) sum = SAT_LO;
    last_err_q = err_bits;
    return sum[OUT_W-1:0];
  endfunction

  function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    case (idx)
      CFG_GAIN_P:    gain_p_q    = val;
      CFG_GAIN_I:    gain_i_q    = val;
      CFG_GAIN_D:    gain_d_q    = val;
      CFG_STEP_TIME: step_time_q = val[16:0];
      CFG_STEP_RATE: step_rate_q = val[30:0];
      default: ;
    endcase
  endfunction

  // monitor: sample handshakes, predict, compare
  always @(posedge clk) begin : monitor
    logic [OUT_W-1:0] want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        load_setting(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (m_tvalid && m_tready) begin
        if (drive_expected.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected drive_out %h with nothing pending", m_tdata);
        end else begin
          want = drive_expected.pop_front();
          results_seen++;
          if (m_tdata !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("result %0d: drive_out expected %h got %h",
                       results_seen, want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        drive_expected.push_back(pid_drive(s_tdata));
        items_taken++;
      end
    end
  end

  // driver: advance the source after each transaction, randomise sink ready
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (pending_errors.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_errors.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !sink_stall && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // one long sink hold-off, counted here
  initial begin
    wait (hold_req);
    @(negedge clk);
    sink_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    sink_stall <= 1'b0;
  end

  task automatic send_error(input logic [DATA_W-1:0] v);
    pending_errors.push_back(v);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || drive_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_period();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'd65536;
      2:       return 32'h0001_FFFF;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0000_2000);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_error();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    endcase
  endfunction

  task automatic pick_settings();
    write_reg(CFG_GAIN_P, rand_gain());
    write_reg(CFG_GAIN_I, rand_gain());
    write_reg(CFG_GAIN_D, rand_gain());
    write_reg(CFG_STEP_TIME, rand_period());
    write_reg(CFG_STEP_RATE, rand_rate());
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, $urandom);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: all gains zero
    send_error(32'h0001_0000);
    send_error(32'hFFFF_8000);
    wait_idle();

    // unit gains, period above one second, zero rate, write to a spare index
    write_reg(CFG_GAIN_P, 32'd65536);
    write_reg(CFG_GAIN_I, 32'd65536);
    write_reg(CFG_GAIN_D, 32'd65536);
    write_reg(CFG_STEP_TIME, 32'h0001_FFFF);
    write_reg(CFG_STEP_RATE, '0);
    write_reg(CFG_SPARE_IDX, 32'h1234_5678);
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    send_error(32'h8000_0000);
    send_error(32'h0000_0001);
    send_error(32'hFFFF_FFFF);
    send_error(32'h0000_8000);
    wait_idle();

    // extreme gains and rate, zero period
    write_reg(CFG_GAIN_P, 32'h7FFF_FFFF);
    write_reg(CFG_GAIN_I, 32'h8000_0000);
    write_reg(CFG_GAIN_D, 32'h7FFF_FFFF);
    write_reg(CFG_STEP_TIME, '0);
    write_reg(CFG_STEP_RATE, 32'hFFFF_FFFF);
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    send_error(32'h7FFF_FFFF);
    send_error(32'h0000_0000);
    send_error(32'h8000_0000);
    send_error(32'h0000_0001);
    wait_idle();

    // drive the integral into both clamps
    write_reg(CFG_GAIN_P, 32'h8000_0000);
    write_reg(CFG_GAIN_I, 32'h7FFF_FFFF);
    write_reg(CFG_GAIN_D, 32'h8000_0000);
    write_reg(CFG_STEP_TIME, 32'd65536);
    write_reg(CFG_STEP_RATE, 32'd65536);
    repeat (3) send_error(32'h4000_0000);
    repeat (3) send_error(32'hC000_0000);
    send_error(32'h0000_0000);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 26; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 26; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        wait_idle();
        pick_settings();
        repeat (30) send_error(rand_error());
        if (ph == 2 && blk == 0) begin
          // keep offering while the sink holds off
          repeat (40) send_error(rand_error());
          hold_req = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures += drive_expected.size();

    $display("%0d error samples accepted, %0d drive results checked, %0d register writes",
             items_taken, results_seen, cfg_writes);
    $display("covered zero and saturating gains, both integral clamps, zero rate, ",
             "long period, spare index and a long sink hold-off");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
